/* rtl/bfd_pkg.sv */
`timescale 1ns / 1ps

package bfd_pkg;

  localparam int PIX_W        = 8;
  localparam int SUM_W        = PIX_W + 1;
  localparam int CHANNELS     = 4;
  localparam int PAIR_W       = SUM_W * CHANNELS;
  localparam int CFG_W        = 11;
  localparam int CFG_INDEX_W  = 2;
  localparam int ROW_W        = 10;
  localparam int HEIGHT_LIMIT = 1024;

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_IMAGE_WIDTH  = 2'd0,
    REG_IMAGE_HEIGHT = 2'd1
  } cfg_reg_t;

  // Handoff from the front stage to the averaging stage.
  typedef struct packed {
    logic              load;
    logic              done;
    logic [PAIR_W-1:0] pair;
  } avg_req_t;

endpackage

/* rtl/bfd_line_mem.sv */
`timescale 1ns / 1ps

module bfd_line_mem #(
  parameter int MAX_WIDTH = 1024,
  localparam int CW = (MAX_WIDTH > 2) ? $clog2(MAX_WIDTH) : 2,
  localparam int AW = CW - 1
) (
  input  logic                       clk,
  input  logic                       wr_en,
  input  logic                       rd_en,
  input  logic [AW-1:0]              addr,
  input  logic [bfd_pkg::PAIR_W-1:0] wr_data,
  output logic [bfd_pkg::PAIR_W-1:0] rd_data
);

  localparam int DEPTH = MAX_WIDTH / 2;

  logic [bfd_pkg::PAIR_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[addr] <= wr_data;
    end
  end

  // Read data only moves when a new read is issued, so it holds while the
  // consuming stage is stalled.
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[addr];
    end
  end

endmodule

/* rtl/bfd_front.sv */
`timescale 1ns / 1ps

module bfd_front #(
  parameter int MAX_WIDTH = 1024,
  localparam int CW = (MAX_WIDTH > 2) ? $clog2(MAX_WIDTH) : 2,
  localparam int AW = CW - 1
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_valid,
  input  logic [bfd_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [bfd_pkg::CFG_W-1:0]       cfg_data,
  input  logic                            accept,
  input  logic [bfd_pkg::PIX_W-1:0]       red_in,
  input  logic [bfd_pkg::PIX_W-1:0]       green_in,
  input  logic [bfd_pkg::PIX_W-1:0]       blue_in,
  input  logic [bfd_pkg::PIX_W-1:0]       alpha_in,
  output logic                            mem_wr_en,
  output logic                            mem_rd_en,
  output logic [AW-1:0]                   mem_addr,
  output logic [bfd_pkg::PAIR_W-1:0]      mem_wr_data,
  output bfd_pkg::avg_req_t               req
);

  localparam int PW = (CW > bfd_pkg::CFG_W) ? CW : bfd_pkg::CFG_W;
  localparam int HW = bfd_pkg::CFG_W;

  logic [bfd_pkg::CFG_W-1:0]     image_width;
  logic [bfd_pkg::CFG_W-1:0]     image_height;
  logic [CW-1:0]                 column_count;
  logic [bfd_pkg::ROW_W-1:0]     row_count;
  logic [4*bfd_pkg::PIX_W-1:0]   pending_pixel;

  logic [bfd_pkg::CFG_W-1:0]     w;
  logic [bfd_pkg::CFG_W-1:0]     h;
  logic [PW-1:0]                 colx;
  logic [PW-1:0]                 wx;
  logic [PW-1:0]                 used_wx;
  logic [HW-1:0]                 rowx;
  logic [HW-1:0]                 used_h;
  logic [4*bfd_pkg::PIX_W-1:0]   pix;
  logic [bfd_pkg::PAIR_W-1:0]    pair;
  logic                          in_area;
  logic                          col_end;

  always_ff @(posedge clk) begin
    if (rst) begin
      image_width  <= bfd_pkg::CFG_W'(16);
      image_height <= bfd_pkg::CFG_W'(16);
    end else if (cfg_valid) begin
      case (cfg_index)
        bfd_pkg::REG_IMAGE_WIDTH:  image_width  <= cfg_data;
        bfd_pkg::REG_IMAGE_HEIGHT: image_height <= cfg_data;
        default: ;
      endcase
    end
  end

  // A zero size counts as one; an oversize saturates at the limit.
  always_comb begin
    if (image_width == '0) begin
      w = bfd_pkg::CFG_W'(1);
    end else if (32'(image_width) > MAX_WIDTH) begin
      w = bfd_pkg::CFG_W'(MAX_WIDTH);
    end else begin
      w = image_width;
    end
    if (image_height == '0) begin
      h = bfd_pkg::CFG_W'(1);
    end else if (32'(image_height) > bfd_pkg::HEIGHT_LIMIT) begin
      h = bfd_pkg::CFG_W'(bfd_pkg::HEIGHT_LIMIT);
    end else begin
      h = image_height;
    end
  end

  assign colx    = PW'(column_count);
  assign wx      = PW'(w);
  assign used_wx = {wx[PW-1:1], 1'b0};
  assign rowx    = HW'(row_count);
  assign used_h  = {h[HW-1:1], 1'b0};
  assign pix     = {alpha_in, blue_in, green_in, red_in};
  assign in_area = column_count[0] && (colx < used_wx);
  assign col_end = (colx >= wx - PW'(1));

  always_comb begin
    for (int c = 0; c < bfd_pkg::CHANNELS; c++) begin
      pair[c*bfd_pkg::SUM_W +: bfd_pkg::SUM_W] =
        bfd_pkg::SUM_W'(pending_pixel[c*bfd_pkg::PIX_W +: bfd_pkg::PIX_W])
        + bfd_pkg::SUM_W'(pix[c*bfd_pkg::PIX_W +: bfd_pkg::PIX_W]);
    end
  end

  // Even rows store the pair sums; odd rows read them back. The same entry is
  // never written and read in the same cycle, so no forwarding.
  assign mem_wr_en   = accept && in_area && !row_count[0];
  assign mem_rd_en   = accept && in_area && row_count[0] && (rowx < used_h);
  assign mem_addr    = column_count[CW-1:1];
  assign mem_wr_data = pair;

  assign req.load = mem_rd_en;
  assign req.pair = pair;
  assign req.done = (colx == used_wx - PW'(1)) && (rowx == used_h - HW'(1));

  always_ff @(posedge clk) begin
    if (rst) begin
      column_count  <= '0;
      row_count     <= '0;
      pending_pixel <= '0;
    end else if (accept) begin
      if (!column_count[0]) begin
        pending_pixel <= pix;
      end
      if (col_end) begin
        column_count <= '0;
        if (rowx >= h - HW'(1)) begin
          row_count <= '0;
        end else begin
          row_count <= row_count + bfd_pkg::ROW_W'(1);
        end
      end else begin
        column_count <= column_count + CW'(1);
      end
    end
  end

endmodule

/* rtl/bfd_avg_out.sv */
`timescale 1ns / 1ps

module bfd_avg_out (
  input  logic                       clk,
  input  logic                       rst,
  input  bfd_pkg::avg_req_t          req,
  input  logic [bfd_pkg::PAIR_W-1:0] above,
  input  logic                       out_stall,
  output logic                       in_stall,
  output logic                       out_valid,
  output logic [bfd_pkg::PIX_W-1:0]  red_out,
  output logic [bfd_pkg::PIX_W-1:0]  green_out,
  output logic [bfd_pkg::PIX_W-1:0]  blue_out,
  output logic [bfd_pkg::PIX_W-1:0]  alpha_out,
  output logic                       image_done
);

  localparam int TOT_W = bfd_pkg::SUM_W + 1;

  logic                        s1_valid;
  logic                        s1_done;
  logic [bfd_pkg::PAIR_W-1:0]  s1_pair;
  logic                        s1_adv;
  logic [4*bfd_pkg::PIX_W-1:0] avg;
  logic [TOT_W-1:0]            tot;

  // The stage waiting on read data moves into the output register whenever
  // that register is empty or being drained this cycle.
  assign s1_adv   = s1_valid && (!out_valid || !out_stall);
  assign in_stall = s1_valid && out_valid && out_stall;

  always_comb begin
    tot = '0;
    for (int c = 0; c < bfd_pkg::CHANNELS; c++) begin
      tot = TOT_W'(above[c*bfd_pkg::SUM_W +: bfd_pkg::SUM_W])
            + TOT_W'(s1_pair[c*bfd_pkg::SUM_W +: bfd_pkg::SUM_W]);
      avg[c*bfd_pkg::PIX_W +: bfd_pkg::PIX_W] = tot[TOT_W-1:2];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (req.load) begin
      s1_valid <= 1'b1;
    end else if (s1_adv) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (req.load) begin
      s1_pair <= req.pair;
      s1_done <= req.done;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_adv) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      red_out    <= avg[0*bfd_pkg::PIX_W +: bfd_pkg::PIX_W];
      green_out  <= avg[1*bfd_pkg::PIX_W +: bfd_pkg::PIX_W];
      blue_out   <= avg[2*bfd_pkg::PIX_W +: bfd_pkg::PIX_W];
      alpha_out  <= avg[3*bfd_pkg::PIX_W +: bfd_pkg::PIX_W];
      image_done <= s1_done;
    end
  end

endmodule

/* rtl/box_filter_downsample_2x2.sv */
`timescale 1ns / 1ps

// 2x2 box-filter downsampler for an RGBA8 pixel stream in row-major order.
// Input channel: in_valid / in_stall with red_in .. alpha_in, one pixel a beat.
// Output channel: out_valid / out_stall with red_out .. alpha_out and
// image_done, one averaged pixel per 2x2 block; image_done marks the last
// block of the image. An odd last column or row is dropped.
// Configuration: cfg_valid / cfg_ready write port, cfg_index 0 is the image
// width and 1 the height (11 bits each, reset 16). cfg_ready is always high;
// write only while no pixel is in flight.
// Throughput is one pixel per cycle while in_stall is low. The block that the
// odd-row, odd-column pixel completes passes the synchronous line-store read,
// then the add and output register, on the way to its output beat.
// Reset clears the counters, the held pixel and both pipeline valids; the
// line store is not cleared, since each entry is written on an even row
// before it is read on the following odd row.
// A stall on the output holds the output register; one more block can wait
// in the read stage, after which in_stall rises until the output drains.
module box_filter_downsample_2x2 #(
  parameter int MAX_WIDTH = 1024
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [bfd_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [bfd_pkg::CFG_W-1:0]       cfg_data,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic [bfd_pkg::PIX_W-1:0]       red_in,
  input  logic [bfd_pkg::PIX_W-1:0]       green_in,
  input  logic [bfd_pkg::PIX_W-1:0]       blue_in,
  input  logic [bfd_pkg::PIX_W-1:0]       alpha_in,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic [bfd_pkg::PIX_W-1:0]       red_out,
  output logic [bfd_pkg::PIX_W-1:0]       green_out,
  output logic [bfd_pkg::PIX_W-1:0]       blue_out,
  output logic [bfd_pkg::PIX_W-1:0]       alpha_out,
  output logic                            image_done
);

  localparam int CW = (MAX_WIDTH > 2) ? $clog2(MAX_WIDTH) : 2;
  localparam int AW = CW - 1;

  logic                       accept;
  logic                       mem_wr_en;
  logic                       mem_rd_en;
  logic [AW-1:0]              mem_addr;
  logic [bfd_pkg::PAIR_W-1:0] mem_wr_data;
  logic [bfd_pkg::PAIR_W-1:0] mem_rd_data;
  bfd_pkg::avg_req_t          req;

  assign cfg_ready = 1'b1;
  assign accept    = in_valid && !in_stall;

  bfd_front #(
    .MAX_WIDTH(MAX_WIDTH)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .cfg_valid  (cfg_valid && cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .accept     (accept),
    .red_in     (red_in),
    .green_in   (green_in),
    .blue_in    (blue_in),
    .alpha_in   (alpha_in),
    .mem_wr_en  (mem_wr_en),
    .mem_rd_en  (mem_rd_en),
    .mem_addr   (mem_addr),
    .mem_wr_data(mem_wr_data),
    .req        (req)
  );

  bfd_line_mem #(
    .MAX_WIDTH(MAX_WIDTH)
  ) u_line_mem (
    .clk    (clk),
    .wr_en  (mem_wr_en),
    .rd_en  (mem_rd_en),
    .addr   (mem_addr),
    .wr_data(mem_wr_data),
    .rd_data(mem_rd_data)
  );

  bfd_avg_out u_avg_out (
    .clk       (clk),
    .rst       (rst),
    .req       (req),
    .above     (mem_rd_data),
    .out_stall (out_stall),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .red_out   (red_out),
    .green_out (green_out),
    .blue_out  (blue_out),
    .alpha_out (alpha_out),
    .image_done(image_done)
  );

`ifndef SYNTHESIS
  a_stall_needs_full_output: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> (out_valid && out_stall))
    else $error("input stalled while the output register can drain");

  a_no_read_write_same_cycle: assert property (@(posedge clk) disable iff (rst)
    mem_rd_en |-> !mem_wr_en)
    else $error("line store read and written in the same cycle");

  a_read_only_on_accept: assert property (@(posedge clk) disable iff (rst)
    (mem_rd_en || mem_wr_en) |-> accept)
    else $error("line store accessed without an accepted beat");

  a_reset_empties_output: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("output valid after reset");
`endif

endmodule

/* verif/box_filter_downsample_2x2_tb.sv */
`timescale 1ns / 1ps

// Tracks the source position, the held even-column pixel and the line of pair
// sums, and queues the averaged block that each accepted pixel completes.
class mip_level_tracker #(int MAX_WIDTH = 1024);

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic [7:0] alpha;
    logic       done;
  } block_avg_t;

  localparam int SLOTS = MAX_WIDTH / 2;

  bit [bfd_pkg::CFG_W-1:0] width_reg;
  bit [bfd_pkg::CFG_W-1:0] height_reg;
  bit [3:0][8:0]           pair_line [SLOTS];
  bit [3:0][7:0]           held_pixel;
  bit [9:0]                col;
  bit [9:0]                row;
  block_avg_t              expected_blocks [$];
  int                      errors;

  function new();
    width_reg  = bfd_pkg::CFG_W'(16);
    height_reg = bfd_pkg::CFG_W'(16);
    held_pixel = '0;
    col        = '0;
    row        = '0;
    errors     = 0;
    foreach (pair_line[i]) pair_line[i] = '0;
  endfunction

  function int clamp_size(bit [bfd_pkg::CFG_W-1:0] v, int limit);
    if (v == 0) return 1;
    if (v > limit) return limit;
    return int'(v);
  endfunction

  function void write_reg(bfd_pkg::cfg_reg_t idx, bit [bfd_pkg::CFG_W-1:0] v);
    case (idx)
      bfd_pkg::REG_IMAGE_WIDTH:  width_reg = v;
      bfd_pkg::REG_IMAGE_HEIGHT: height_reg = v;
      default: ;
    endcase
  endfunction

  function bit idle();
    return expected_blocks.size() == 0;
  endfunction

  function bit at_image_start();
    return col == 0 && row == 0;
  endfunction

  // Channel 0 is red, channel 3 is alpha.
  function void note_pixel(bit [3:0][7:0] pix);
    int           w;
    int           h;
    int           used_w;
    int           used_h;
    int           slot;
    bit [3:0][8:0] pair;
    bit [9:0]     total;
    bit [3:0][7:0] avg;
    block_avg_t   blk;
    w      = clamp_size(width_reg, MAX_WIDTH);
    h      = clamp_size(height_reg, bfd_pkg::HEIGHT_LIMIT);
    used_w = w & ~1;
    used_h = h & ~1;
    if (!col[0]) begin
      held_pixel = pix;
    end else if (col < used_w) begin
      for (int c = 0; c < 4; c++) pair[c] = {1'b0, held_pixel[c]} + {1'b0, pix[c]};
      slot = int'(col >> 1) % SLOTS;
      if (!row[0]) begin
        pair_line[slot] = pair;
      end else if (row < used_h) begin
        for (int c = 0; c < 4; c++) begin
          total  = {1'b0, pair_line[slot][c]} + {1'b0, pair[c]};
          avg[c] = total[9:2];
        end
        blk.red   = avg[0];
        blk.green = avg[1];
        blk.blue  = avg[2];
        blk.alpha = avg[3];
        blk.done  = (col == used_w - 1) && (row == used_h - 1);
        expected_blocks.push_back(blk);
      end
    end
    // A counter at or past the last index wraps, which also covers a size
    // that shrank in the middle of an image.
    if (col >= w - 1) begin
      col = '0;
      row = (row >= h - 1) ? 10'd0 : row + 10'd1;
    end else begin
      col = col + 10'd1;
    end
  endfunction

  function void compare_field(string field, logic [7:0] want, logic [7:0] got);
    if (got !== want) begin
      errors++;
      $display("%0t: %s mismatch: expected %0d, got %0d", $time, field, want, got);
    end
  endfunction

  function void check_block(block_avg_t got);
    block_avg_t want;
    if (expected_blocks.size() == 0) begin
      errors++;
      $display("%0t: output beat with nothing expected: expected none, got %h", $time, got);
      return;
    end
    want = expected_blocks.pop_front();
    compare_field("red_out", want.red, got.red);
    compare_field("green_out", want.green, got.green);
    compare_field("blue_out", want.blue, got.blue);
    compare_field("alpha_out", want.alpha, got.alpha);
    compare_field("image_done", {7'd0, want.done}, {7'd0, got.done});
  endfunction

endclass

module box_filter_downsample_2x2_tb;

  localparam int MAX_W         = 1024;
  localparam int CYCLE_LIMIT   = 600000;
  localparam int RANDOM_PIXELS = 720;
  localparam int FILL_PIXELS   = 40;
  localparam int PHASE1_START  = 370;
  localparam int PHASE2_START  = 740;

  logic                            clk;
  logic                            rst;
  logic                            cfg_valid;
  logic                            cfg_ready;
  logic [bfd_pkg::CFG_INDEX_W-1:0] cfg_index;
  logic [bfd_pkg::CFG_W-1:0]       cfg_data;
  logic                            in_valid;
  logic                            in_stall;
  logic [bfd_pkg::PIX_W-1:0]       red_in;
  logic [bfd_pkg::PIX_W-1:0]       green_in;
  logic [bfd_pkg::PIX_W-1:0]       blue_in;
  logic [bfd_pkg::PIX_W-1:0]       alpha_in;
  logic                            out_valid;
  logic                            out_stall = 1'b0;
  logic [bfd_pkg::PIX_W-1:0]       red_out;
  logic [bfd_pkg::PIX_W-1:0]       green_out;
  logic [bfd_pkg::PIX_W-1:0]       blue_out;
  logic [bfd_pkg::PIX_W-1:0]       alpha_out;
  logic                            image_done;

  int tx_gap_pct   = 18;
  int rx_stall_pct = 83;
  int pixels_sent  = 0;
  int cycle_count;

  mip_level_tracker #(MAX_W) half_image;

  box_filter_downsample_2x2 #(
    .MAX_WIDTH(MAX_W)
  ) u_top (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .red_in    (red_in),
    .green_in  (green_in),
    .blue_in   (blue_in),
    .alpha_in  (alpha_in),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .red_out   (red_out),
    .green_out (green_out),
    .blue_out  (blue_out),
    .alpha_out (alpha_out),
    .image_done(image_done)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  always @(negedge clk) begin
    out_stall <= ($urandom_range(99) < rx_stall_pct);
  end

  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      half_image.check_block({red_out, green_out, blue_out, alpha_out, image_done});
    end
  end

  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("** box_filter_downsample_2x2: FAILED **");
    $finish;
  end

  // Sender mostly sending and receiver mostly stalled first, then the reverse,
  // then both at full rate.
  function void update_idle_mix();
    if (pixels_sent < PHASE1_START) begin
      tx_gap_pct   = 18;
      rx_stall_pct = 83;
    end else if (pixels_sent < PHASE2_START) begin
      tx_gap_pct   = 83;
      rx_stall_pct = 18;
    end else begin
      tx_gap_pct   = 0;
      rx_stall_pct = 0;
    end
  endfunction

  function logic [7:0] pick_channel();
    case ($urandom_range(7))
      0:       return 8'd0;
      1:       return 8'd255;
      default: return 8'($urandom_range(255));
    endcase
  endfunction

  function int pick_size();
    case ($urandom_range(9))
      0:       return 0;
      1:       return 1;
      7, 8:    return $urandom_range(24, 9);
      9:       return $urandom_range(40, 25);
      default: return $urandom_range(8, 2);
    endcase
  endfunction

  // All tasks start and end at a falling edge.
  task automatic send_pixel(logic [7:0] r, logic [7:0] g, logic [7:0] b, logic [7:0] a);
    while ($urandom_range(99) < tx_gap_pct) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    red_in   = r;
    green_in = g;
    blue_in  = b;
    alpha_in = a;
    in_valid = 1'b1;
    do @(posedge clk); while (in_stall);
    half_image.note_pixel({a, b, g, r});
    pixels_sent++;
    update_idle_mix();
    @(negedge clk);
  endtask

  task automatic send_random(int n);
    repeat (n) send_pixel(pick_channel(), pick_channel(), pick_channel(), pick_channel());
  endtask

  task automatic wait_until_drained();
    in_valid = 1'b0;
    while (!half_image.idle()) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic cfg_write(bfd_pkg::cfg_reg_t idx, logic [bfd_pkg::CFG_W-1:0] value);
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data  = value;
    do @(posedge clk); while (!cfg_ready);
    half_image.write_reg(idx, value);
    @(negedge clk);
  endtask

  task automatic set_size(int w, int h);
    wait_until_drained();
    cfg_write(bfd_pkg::REG_IMAGE_WIDTH, bfd_pkg::CFG_W'(w));
    cfg_write(bfd_pkg::REG_IMAGE_HEIGHT, bfd_pkg::CFG_W'(h));
    cfg_valid = 1'b0;
  endtask

  initial begin
    int w;
    int h;
    int n;
    int random_start;
    half_image = new();
    rst       = 1'b1;
    cfg_valid = 1'b0;
    cfg_index = bfd_pkg::REG_IMAGE_WIDTH;
    cfg_data  = '0;
    in_valid  = 1'b0;
    red_in    = '0;
    green_in  = '0;
    blue_in   = '0;
    alpha_in  = '0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // One full image at the reset size before any register is written.
    send_random(256);

    set_size(2, 2);
    repeat (4) send_pixel(8'd0, 8'd0, 8'd0, 8'd0);
    repeat (4) send_pixel(8'd255, 8'd255, 8'd255, 8'd255);
    // Sums that truncate differently in each channel.
    send_pixel(8'd255, 8'd0, 8'd1, 8'd128);
    send_pixel(8'd255, 8'd0, 8'd2, 8'd127);
    send_pixel(8'd255, 8'd0, 8'd3, 8'd128);
    send_pixel(8'd254, 8'd3, 8'd3, 8'd127);
    set_size(1, 1);
    send_random(2);
    // A zero size acts as one.
    set_size(0, 0);
    send_random(2);
    // Odd width and height: the last column and row are dropped.
    set_size(3, 3);
    send_random(9);

    // Oversize registers, then a smaller size inside the image. The first
    // row here writes every line entry that the random sizes below can
    // reach, so later size changes inside an image never read stale memory.
    set_size(2047, 2047);
    send_random(FILL_PIXELS);
    set_size(2, 2);
    while (!half_image.at_image_start()) send_random(1);

    random_start = pixels_sent;
    while (pixels_sent - random_start < RANDOM_PIXELS) begin
      w = pick_size();
      h = pick_size();
      set_size(w, h);
      n = (w == 0 ? 1 : w) * (h == 0 ? 1 : h);
      case ($urandom_range(7))
        0, 1: begin
          if (n > 1) begin
            send_random($urandom_range(n - 1, 1));
            set_size(pick_size(), pick_size());
          end
          while (!half_image.at_image_start()) send_random(1);
        end
        2: begin
          send_random(n / 2);
          wait_until_drained();
          send_random(n - n / 2);
        end
        default: send_random(n);
      endcase
    end

    wait_until_drained();
    repeat (8) @(negedge clk);
    if (half_image.errors == 0 && half_image.idle()) begin
      $display("** box_filter_downsample_2x2: PASSED **");
    end else begin
      $display("** box_filter_downsample_2x2: FAILED **");
    end
    $finish;
  end

endmodule
